// ===== hw/rtl/icdf_pkg.sv =====
// Shared types and constants for the inverse CDF table interpolator.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package icdf_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int CFG_W           = 9;
    localparam int IDX_W           = 8;
    localparam int DATA_W          = 32;
    localparam int S_TDATA_W       = 104;
    localparam int CNT_W           = 5;
    localparam logic [CFG_W-1:0] ENTRIES_RST = 9'd2;

    typedef enum logic [1:0] {
        ST_INTERP = 2'd0,
        ST_EXACT  = 2'd1,
        ST_BELOW  = 2'd2,
        ST_BEYOND = 2'd3
    } t_status;

    typedef struct packed {
        logic    load_wr;
        logic    q_start;
        logic    scan_en;
        logic    mul_go;
        logic    div_init;
        logic    div_step;
        logic    out_load;
        t_status code;
    } t_cmd;

    typedef struct packed {
        logic exact;
        logic interp;
        logic last;
        logic at_top;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/icdf_ctrl.sv =====
// Controller state machine of the inverse CDF table interpolator.
// Sequences load, scan, multiply, divide and output; depends on icdf_pkg.
module icdf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_kind,
    output logic              o_s_tready,
    input  icdf_pkg::t_sts    i_sts,
    output icdf_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_DINIT,
        S_DIV,
        S_FINISH
    } t_state;

    t_state            r_state, n_state;
    icdf_pkg::t_status r_code, n_code;
    logic              accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        case (r_state)
            S_IDLE: begin
                if (accept && i_kind) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.exact) begin
                    n_code  = icdf_pkg::ST_EXACT;
                    n_state = S_FINISH;
                end else if (i_sts.interp) begin
                    n_code  = icdf_pkg::ST_INTERP;
                    n_state = S_MUL;
                end else if (i_sts.last) begin
                    n_code  = i_sts.at_top ? icdf_pkg::ST_BEYOND : icdf_pkg::ST_BELOW;
                    n_state = S_FINISH;
                end
            end
            S_MUL:   n_state = S_DINIT;
            S_DINIT: n_state = S_DIV;
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= icdf_pkg::ST_BELOW;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.load_wr  = accept && !i_kind;
        o_cmd.q_start  = accept && i_kind;
        o_cmd.scan_en  = (r_state == S_SCAN);
        o_cmd.mul_go   = (r_state == S_MUL);
        o_cmd.div_init = (r_state == S_DINIT);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.out_load = (r_state == S_FINISH) && i_sts.out_free;
        o_cmd.code     = r_code;
    end

endmodule

// ===== hw/rtl/icdf_datapath.sv =====
// Datapath of the inverse CDF table interpolator: table memories, scan
// compare, multiplier, restoring divider and output register; uses icdf_pkg.
module icdf_datapath #(
    parameter int TABLE_DEPTH = icdf_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  icdf_pkg::t_cmd                i_cmd,
    output icdf_pkg::t_sts                o_sts,
    input  logic                          i_cfg_we,
    input  logic [icdf_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic [icdf_pkg::IDX_W-1:0]    i_idx,
    input  logic [icdf_pkg::DATA_W-1:0]   i_arg,
    input  logic [icdf_pkg::DATA_W-1:0]   i_prob,
    input  logic [icdf_pkg::DATA_W-1:0]   i_probe,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [icdf_pkg::DATA_W-1:0]   o_arg,
    output logic [1:0]                    o_status
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int DW = icdf_pkg::DATA_W;
    localparam int CW = icdf_pkg::CNT_W;

    logic [DW-1:0] r_arg_mem  [TABLE_DEPTH];
    logic [DW-1:0] r_prob_mem [TABLE_DEPTH];

    logic [icdf_pkg::CFG_W-1:0] r_entries;
    logic [31:0]   ent_ext, n_eff, last_ext, idx_ext;
    logic [AW-1:0] last_idx, wr_addr;
    logic          wr_ok;

    logic [AW-1:0] r_rd_idx, r_dv_idx;
    logic          r_dv;
    logic [DW-1:0] r_rd_prob, r_rd_arg;
    logic [DW-1:0] r_pv_p, r_pv_a;
    logic [DW-1:0] r_probe;
    logic [DW-1:0] r_a0, r_a1, r_dp, r_dy, r_dx;
    logic          r_down;
    logic          cmp_ok, eq_prev, cur_down;

    logic [2*DW-1:0] r_prod;
    logic [DW-1:0]   r_rem, r_quo;
    logic [CW-1:0]   r_cnt;
    logic [DW:0]     trial, diff;
    logic            ge;

    logic          r_out_valid;
    logic [DW-1:0] r_out_arg, sel_arg;
    logic [1:0]    r_out_st;

    assign ent_ext  = 32'(r_entries);
    assign n_eff    = (ent_ext < 32'd2) ? 32'd2 :
                      (ent_ext > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : ent_ext;
    assign last_ext = n_eff - 32'd1;
    assign last_idx = last_ext[AW-1:0];
    assign idx_ext  = 32'(i_idx);
    assign wr_addr  = idx_ext[AW-1:0];
    assign wr_ok    = idx_ext < 32'(TABLE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= icdf_pkg::ENTRIES_RST;
        end else if (i_cfg_we) begin
            r_entries <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && wr_ok) begin
            r_arg_mem[wr_addr]  <= i_arg;
            r_prob_mem[wr_addr] <= i_prob;
        end
        r_rd_arg  <= r_arg_mem[r_rd_idx];
        r_rd_prob <= r_prob_mem[r_rd_idx];
    end

    assign cmp_ok   = r_dv && (r_dv_idx != '0);
    assign eq_prev  = (r_probe == r_pv_p);
    assign cur_down = r_rd_arg < r_pv_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else if (i_cmd.q_start) begin
            r_dv <= 1'b0;
        end else if (i_cmd.scan_en) begin
            r_dv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_start) begin
            r_rd_idx <= '0;
            r_probe  <= i_probe;
        end else if (i_cmd.scan_en) begin
            r_dv_idx <= r_rd_idx;
            if (r_rd_idx != last_idx) begin
                r_rd_idx <= r_rd_idx + AW'(1);
            end
            if (r_dv) begin
                r_pv_p <= r_rd_prob;
                r_pv_a <= r_rd_arg;
            end
            if (cmp_ok) begin
                r_a0   <= r_pv_a;
                r_a1   <= r_rd_arg;
                r_dp   <= r_probe - r_pv_p;
                r_dy   <= r_rd_prob - r_pv_p;
                r_down <= cur_down;
                r_dx   <= cur_down ? (r_pv_a - r_rd_arg) : (r_rd_arg - r_pv_a);
            end
        end
    end

    assign trial = {r_rem, r_quo[DW-1]};
    assign diff  = trial - {1'b0, r_dy};
    assign ge    = trial >= {1'b0, r_dy};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_go) begin
            r_prod <= (2*DW)'(r_dp) * (2*DW)'(r_dx);
        end
        if (i_cmd.div_init) begin
            r_rem <= r_prod[2*DW-1:DW];
            r_quo <= r_prod[DW-1:0];
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
            r_cnt <= r_cnt + CW'(1);
        end
    end

    always_comb begin
        case (i_cmd.code)
            icdf_pkg::ST_INTERP: sel_arg = r_down ? (r_a0 - r_quo) : (r_a0 + r_quo);
            icdf_pkg::ST_EXACT:  sel_arg = r_a0;
            icdf_pkg::ST_BEYOND: sel_arg = r_a1;
            default:             sel_arg = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_arg <= sel_arg;
            r_out_st  <= i_cmd.code;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_arg      = r_out_arg;
    assign o_status   = r_out_st;

    always_comb begin
        o_sts          = '0;
        o_sts.exact    = cmp_ok && eq_prev;
        o_sts.interp   = cmp_ok && !eq_prev && (r_pv_p < r_probe) && (r_probe <= r_rd_prob);
        o_sts.last     = cmp_ok && (r_dv_idx == last_idx);
        o_sts.at_top   = r_probe >= r_rd_prob;
        o_sts.div_last = (r_cnt == {CW{1'b1}});
        o_sts.out_free = !r_out_valid || i_m_tready;
    end

endmodule

// ===== hw/rtl/inverse_cdf_table_interpolator.sv =====
// Load item: the next item can be accepted in the following cycle.
// Query item: scan of n = clamp(entries_in_use, 2, TABLE_DEPTH) pairs from one read
// port, then a multiply and a 32-step divide when interpolated, then a load into the
// output register once it is free; no new item is accepted until that load is done.
// Reset is synchronous, active low: clears the controller, output valid and sets
// entries_in_use to 2; table contents stay undefined until loaded.
module inverse_cdf_table_interpolator #(
    parameter int TABLE_DEPTH = icdf_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [icdf_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // entry_index[7:0], entry_arg[39:8], entry_prob[71:40], probe[103:72]
    input  logic [icdf_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // kind[0]
    input  logic [0:0]                      i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // sample_arg[31:0]
    output logic [icdf_pkg::DATA_W-1:0]     o_m_tdata,
    // status[1:0]
    output logic [1:0]                      o_m_tuser
);

    icdf_pkg::t_cmd cmd;
    icdf_pkg::t_sts sts;

    icdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_kind     (i_s_tuser[0]),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    icdf_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_idx       (i_s_tdata[7:0]),
        .i_arg       (i_s_tdata[39:8]),
        .i_prob      (i_s_tdata[71:40]),
        .i_probe     (i_s_tdata[103:72]),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_arg       (o_m_tdata),
        .o_status    (o_m_tuser)
    );

endmodule

// ===== hw/rtl/icdf_checker.sv =====
// Port-level checker for the inverse CDF table interpolator, bound to the top.
// Depends on icdf_pkg.
module icdf_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_we,
    input logic [icdf_pkg::CFG_W-1:0]      i_cfg_wdata,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic [icdf_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input logic [0:0]                      i_s_tuser,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [icdf_pkg::DATA_W-1:0]     o_m_tdata,
    input logic [1:0]                      o_m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("output item changed while stalled");

    a_below_zero: assert property (@(posedge i_clk)
        o_m_tvalid && (o_m_tuser == icdf_pkg::ST_BELOW) |-> (o_m_tdata == '0))
        else $error("below-table result is not zero");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser[0] |=> !o_s_tready)
        else $error("input ready right after a query");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind inverse_cdf_table_interpolator icdf_checker u_icdf_checker (.*);
